[src/swuv_pkg.sv]
package swuv_pkg;

	// Field widths of the byte and result words
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 4;
	localparam int PORT_W      = 16;
	localparam int LEN_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int BYTE_CNT_W  = 9;
	localparam int PORT_ACC_W  = 17;
	localparam int OCTET_W     = 10;

	// Default longest DNS label
	localparam int LABEL_MAX_DEF = 63;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_URL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH = 2'd2;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] MAX_URL_RST  = 8'd255;
	localparam logic [CFG_DATA_W-1:0] MAX_HOST_RST = 8'd253;
	localparam logic [CFG_DATA_W-1:0] MAX_PATH_RST = 8'd128;

	localparam logic [PORT_W-1:0]     DEFAULT_PORT = 16'd443;
	localparam logic [PORT_ACC_W-1:0] PORT_LIMIT   = 17'd65535;
	localparam logic [OCTET_W-1:0]    OCTET_LIMIT  = 10'd255;
	localparam logic [CHAR_W-1:0]     CTRL_TOP     = 8'h20;
	localparam logic [CHAR_W-1:0]     DEL_CHAR     = 8'h7F;

	// Fault flag bit positions
	localparam int FL_BADCHAR   = 0;
	localparam int FL_QUERY     = 1;
	localparam int FL_USERINFO  = 2;
	localparam int FL_BRACKET   = 3;
	localparam int FL_NOTDOTNUM = 4;
	localparam int FL_IPV4BAD   = 5;
	localparam int FL_NAMEBAD   = 6;
	localparam int FL_PATHBAD   = 7;

	typedef enum logic [1:0] {
		PH_SCHEME = 2'd0,
		PH_AUTH   = 2'd1,
		PH_PATH   = 2'd2
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 4'd0,
		ST_EMPTY       = 4'd1,
		ST_TOO_LONG    = 4'd2,
		ST_BAD_CHAR    = 4'd3,
		ST_INSECURE    = 4'd4,
		ST_UNSUPPORTED = 4'd5,
		ST_QUERY       = 4'd6,
		ST_USERINFO    = 4'd7,
		ST_NO_PATH     = 4'd8,
		ST_BAD_HOST    = 4'd9,
		ST_BAD_PORT    = 4'd10,
		ST_BAD_PATH    = 4'd11
	} status_t;

	// Running parse state of one URL
	typedef struct packed {
		logic [BYTE_CNT_W-1:0] byte_count;
		logic [1:0]            scheme_kind;   // bit0 wss ruled out, bit1 ws ruled out
		phase_t                phase;
		logic [7:0]            flags;
		logic [1:0]            colon_count;
		logic [LEN_W-1:0]      host_count;
		logic [PORT_ACC_W-1:0] port_acc;
		logic [2:0]            port_digits;
		logic                  prev_dash;
		logic [OCTET_W-1:0]    octet_value;
		logic [1:0]            octet_digits;
		logic [2:0]            octet_count;
		logic [LEN_W-1:0]      path_count;
	} url_state_t;

	localparam url_state_t STATE_RST = '{
		byte_count:   '0,
		scheme_kind:  '0,
		phase:        PH_SCHEME,
		flags:        '0,
		colon_count:  '0,
		host_count:   '0,
		port_acc:     '0,
		port_digits:  '0,
		prev_dash:    1'b0,
		octet_value:  '0,
		octet_digits: '0,
		octet_count:  '0,
		path_count:   '0
	};

	typedef struct packed {
		logic [CFG_DATA_W-1:0] max_url;
		logic [CFG_DATA_W-1:0] max_host;
		logic [CFG_DATA_W-1:0] max_path;
	} cfg_regs_t;

	typedef struct packed {
		status_t          status;
		logic [PORT_W-1:0] port;
		logic             is_ipv4;
		logic [LEN_W-1:0] host_length;
		logic [LEN_W-1:0] path_length;
	} result_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// Expected byte of "wss://" at a position
	function automatic logic [CHAR_W-1:0] wss_char(input logic [2:0] i);
		logic [CHAR_W-1:0] r;
		unique case (i)
			3'd0:    r = 8'h77;
			3'd1:    r = 8'h73;
			3'd2:    r = 8'h73;
			3'd3:    r = 8'h3A;
			3'd4:    r = 8'h2F;
			3'd5:    r = 8'h2F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Expected byte of "ws://" at a position
	function automatic logic [CHAR_W-1:0] ws_char(input logic [2:0] i);
		logic [CHAR_W-1:0] r;
		unique case (i)
			3'd0:    r = 8'h77;
			3'd1:    r = 8'h73;
			3'd2:    r = 8'h3A;
			3'd3:    r = 8'h2F;
			3'd4:    r = 8'h2F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[src/swuv_byte_if.sv]
interface swuv_byte_if;
	import swuv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	logic              no_data;

	modport source (output valid, output char_code, output last, output no_data, input ready);
	modport sink (input valid, input char_code, input last, input no_data, output ready);
endinterface

[src/swuv_result_if.sv]
interface swuv_result_if;
	import swuv_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PORT_W-1:0]   port;
	logic                is_ipv4;
	logic [LEN_W-1:0]    host_length;
	logic [LEN_W-1:0]    path_length;

	modport source (output valid, output status, output port, output is_ipv4,
		output host_length, output path_length, input ready);
	modport sink (input valid, input status, input port, input is_ipv4,
		input host_length, input path_length, output ready);
endinterface

[src/swuv_cfg_if.sv]
interface swuv_cfg_if;
	import swuv_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/swuv_classify.sv]
module swuv_classify (
	input  swuv_pkg::url_state_t st,
	input  logic                 label_zero,
	input  swuv_pkg::cfg_regs_t  regs,
	output swuv_pkg::result_t    res
);
	import swuv_pkg::*;

	status_t status;
	logic    wss_ok;
	logic    ws_ok;
	logic    host_bad;
	logic    port_bad;
	logic    ipv4;
	logic    ip_bad;
	logic    name_bad;

	// Pick the first failing check in priority order
	always_comb begin
		wss_ok   = (st.byte_count >= 9'd6) && !st.scheme_kind[0];
		ws_ok    = (st.byte_count >= 9'd5) && !st.scheme_kind[1];
		host_bad = (st.host_count == '0) || st.flags[FL_BRACKET] ||
			(st.colon_count >= 2'd2) || (st.host_count > regs.max_host);
		port_bad = (st.colon_count == 2'd1) &&
			((st.port_digits == 3'd0) || (st.port_digits > 3'd5) ||
			(st.port_acc == '0) || (st.port_acc > PORT_LIMIT));
		ipv4     = !st.flags[FL_NOTDOTNUM];
		ip_bad   = st.flags[FL_IPV4BAD] || (st.octet_digits == 2'd0) ||
			(st.octet_value > OCTET_LIMIT) || (st.octet_count != 3'd3);
		name_bad = st.flags[FL_NAMEBAD] || label_zero || st.prev_dash;

		priority if (st.byte_count == '0) begin
			status = ST_EMPTY;
		end else if (st.byte_count > {1'b0, regs.max_url}) begin
			status = ST_TOO_LONG;
		end else if (st.flags[FL_BADCHAR]) begin
			status = ST_BAD_CHAR;
		end else if (!wss_ok) begin
			status = ws_ok ? ST_INSECURE : ST_UNSUPPORTED;
		end else if (st.flags[FL_QUERY]) begin
			status = ST_QUERY;
		end else if (st.flags[FL_USERINFO]) begin
			status = ST_USERINFO;
		end else if (st.phase != PH_PATH) begin
			status = ST_NO_PATH;
		end else if (host_bad) begin
			status = ST_BAD_HOST;
		end else if (port_bad) begin
			status = ST_BAD_PORT;
		end else if (ipv4 ? ip_bad : name_bad) begin
			status = ST_BAD_HOST;
		end else if ((st.path_count > regs.max_path) || st.flags[FL_PATHBAD]) begin
			status = ST_BAD_PATH;
		end else begin
			status = ST_OK;
		end

		// Report details only for an accepted URL
		res.status = status;
		if (status == ST_OK) begin
			res.port        = (st.colon_count == 2'd1) ? st.port_acc[PORT_W-1:0] : DEFAULT_PORT;
			res.is_ipv4     = ipv4;
			res.host_length = st.host_count;
			res.path_length = st.path_count;
		end else begin
			res.port        = '0;
			res.is_ipv4     = 1'b0;
			res.host_length = '0;
			res.path_length = '0;
		end
	end
endmodule

[src/secure_websocket_url_validator_top.sv]
// Secure WebSocket URL checker.
// chars: one URL byte per word (char_code), last marks the final word of a URL,
//   no_data with last ends the URL without adding a byte (alone it is ignored).
// verdict: one word per URL, issued for its last word: status, and when the
//   status is ok the port (443 if none given), the IPv4 mark and the host and
//   path lengths; those fields are zero for any other status.
// cfg: register writes (0 max URL length, 1 max host length, 2 max path
//   length), always ready; write only while no URL is in flight.
// Throughput: one byte per cycle unless a stalled verdict holds the input. Each byte
//   is held in an input register, then a single pass of flag and counter logic
//   updates the parse state and, on the last byte, loads the result register,
//   which offers the verdict.
// A stalled verdict holds in the result register; bytes keep flowing until a
//   further last word reaches the input register. That word waits there, with
//   chars ready low, until the verdict is taken.
// Reset clears the parse state and the pipeline and restores the register
//   defaults 255, 253 and 128.
module secure_websocket_url_validator_top #(
	parameter int LABEL_MAX = swuv_pkg::LABEL_MAX_DEF
) (
	input logic          clk,
	input logic          arst_n,
	swuv_byte_if.sink    chars,
	swuv_result_if.source verdict,
	swuv_cfg_if.sink     cfg
);
	import swuv_pkg::*;

	localparam int LBL_W = $clog2(LABEL_MAX + 1);

	// Input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              no_data_s1;
	logic              proceed;

	// Parse state
	url_state_t        st_q;
	url_state_t        st_n;
	logic [LBL_W-1:0]  lbl_q;
	logic [LBL_W-1:0]  lbl_n;
	logic [CHAR_W-1:0] c;

	cfg_regs_t         regs_q;
	result_t           res_d;
	result_t           res_q;
	logic              res_valid_q;

	assign proceed     = valid_s1 && (!last_s1 || !res_valid_q || verdict.ready);
	assign chars.ready = !valid_s1 || proceed;
	assign cfg.ready   = 1'b1;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1    <= chars.char_code;
			last_s1    <= chars.last;
			no_data_s1 <= chars.no_data;
		end
	end

	// Write configuration registers; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_url  <= MAX_URL_RST;
			regs_q.max_host <= MAX_HOST_RST;
			regs_q.max_path <= MAX_PATH_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MAX_URL:  regs_q.max_url  <= cfg.data;
				REG_MAX_HOST: regs_q.max_host <= cfg.data;
				REG_MAX_PATH: regs_q.max_path <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance the parse state by one byte
	always_comb begin
		st_n = st_q;
		lbl_n = lbl_q;
		c = char_s1;
		if (!no_data_s1) begin
			if (st_q.byte_count != '1) begin
				st_n.byte_count = st_q.byte_count + 1'b1;
			end
			if ((c <= CTRL_TOP) || (c >= DEL_CHAR)) begin
				st_n.flags[FL_BADCHAR] = 1'b1;
			end
			unique case (st_q.phase)
				PH_SCHEME: begin
					// Match against both schemes; enter the host after "wss://"
					if (st_q.byte_count < 9'd6) begin
						if (c != wss_char(st_q.byte_count[2:0])) begin
							st_n.scheme_kind[0] = 1'b1;
						end
						if ((st_q.byte_count < 9'd5) && (c != ws_char(st_q.byte_count[2:0]))) begin
							st_n.scheme_kind[1] = 1'b1;
						end
						if ((st_q.byte_count == 9'd5) && !st_n.scheme_kind[0]) begin
							st_n.phase = PH_AUTH;
						end
					end
				end
				PH_AUTH: begin
					if ((c == 8'h3F) || (c == 8'h23)) begin
						st_n.flags[FL_QUERY] = 1'b1;
					end
					if (c == 8'h2F) begin
						st_n.phase = PH_PATH;
						st_n.path_count = 8'd1;
					end else begin
						if (c == 8'h40) begin
							st_n.flags[FL_USERINFO] = 1'b1;
						end
						if (c == 8'h3A) begin
							if (st_q.colon_count != 2'd3) begin
								st_n.colon_count = st_q.colon_count + 1'b1;
							end
						end else if (st_q.colon_count == 2'd0) begin
							// Host byte
							if ((st_q.host_count == '0) && (c == 8'h5B)) begin
								st_n.flags[FL_BRACKET] = 1'b1;
							end
							if (st_q.host_count != '1) begin
								st_n.host_count = st_q.host_count + 1'b1;
							end
							if (!is_digit(c) && (c != 8'h2E)) begin
								st_n.flags[FL_NOTDOTNUM] = 1'b1;
							end
							// Dotted IPv4 tracking
							if (is_digit(c)) begin
								if (st_q.octet_digits == 2'd3) begin
									st_n.flags[FL_IPV4BAD] = 1'b1;
								end else begin
									st_n.octet_value = st_q.octet_value * 10'd10 +
										{6'd0, c[3:0]};
									st_n.octet_digits = st_q.octet_digits + 1'b1;
								end
							end else if (c == 8'h2E) begin
								if ((st_q.octet_digits == 2'd0) || (st_q.octet_value > OCTET_LIMIT)) begin
									st_n.flags[FL_IPV4BAD] = 1'b1;
								end
								if (st_q.octet_count != 3'd7) begin
									st_n.octet_count = st_q.octet_count + 1'b1;
								end
								st_n.octet_value = '0;
								st_n.octet_digits = '0;
							end
							// DNS label tracking
							if (c == 8'h2E) begin
								if ((lbl_q == '0) || st_q.prev_dash) begin
									st_n.flags[FL_NAMEBAD] = 1'b1;
								end
								lbl_n = '0;
							end else begin
								if (!is_alnum(c) && (c != 8'h2D)) begin
									st_n.flags[FL_NAMEBAD] = 1'b1;
								end
								if ((lbl_q == '0) && (c == 8'h2D)) begin
									st_n.flags[FL_NAMEBAD] = 1'b1;
								end
								if (lbl_q >= LBL_W'(LABEL_MAX)) begin
									st_n.flags[FL_NAMEBAD] = 1'b1;
								end else begin
									lbl_n = lbl_q + 1'b1;
								end
							end
							st_n.prev_dash = (c == 8'h2D);
						end else if (st_q.colon_count == 2'd1) begin
							// Port digits; anything else spoils the port
							if (is_digit(c) && (st_q.port_digits < 3'd5)) begin
								st_n.port_acc = st_q.port_acc * 17'd10 + {13'd0, c[3:0]};
								st_n.port_digits = st_q.port_digits + 1'b1;
							end else begin
								st_n.port_digits = 3'd7;
							end
						end
					end
				end
				PH_PATH: begin
					if ((c == 8'h3F) || (c == 8'h23)) begin
						st_n.flags[FL_QUERY] = 1'b1;
					end
					if (st_q.path_count != '1) begin
						st_n.path_count = st_q.path_count + 1'b1;
					end
					if (!is_alnum(c) && (c != 8'h2D) && (c != 8'h2E) && (c != 8'h5F) &&
						(c != 8'h7E) && (c != 8'h2F)) begin
						st_n.flags[FL_PATHBAD] = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	swuv_classify u_classify (
		.st         (st_n),
		.label_zero (lbl_n == '0),
		.regs       (regs_q),
		.res        (res_d)
	);

	// Hold the parse state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RST;
			lbl_q <= '0;
		end else if (proceed) begin
			if (last_s1) begin
				st_q  <= STATE_RST;
				lbl_q <= '0;
			end else begin
				st_q  <= st_n;
				lbl_q <= lbl_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proceed && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && last_s1) begin
			res_q <= res_d;
		end
	end

	assign verdict.valid       = res_valid_q;
	assign verdict.status      = res_q.status;
	assign verdict.port        = res_q.port;
	assign verdict.is_ipv4     = res_q.is_ipv4;
	assign verdict.host_length = res_q.host_length;
	assign verdict.path_length = res_q.path_length;

	// Parse state is back at reset after a URL ends
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && last_s1) |=> (st_q == STATE_RST) && (lbl_q == '0))
		else $error("parse state not cleared after last byte");

	// A refused URL reports no details
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status != ST_OK)) |->
		((res_q.port == '0) && !res_q.is_ipv4 && (res_q.host_length == '0) &&
		(res_q.path_length == '0)))
		else $error("detail fields set on a refused URL");

	// An accepted URL has a host, a path and a nonzero port
	a_ok_details: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status == ST_OK)) |->
		((res_q.port != '0) && (res_q.host_length != '0) && (res_q.path_length != '0)))
		else $error("accepted URL with empty host, path or port");

	// Input stalls only behind a last byte waiting on a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (valid_s1 && last_s1 && res_valid_q && !verdict.ready))
		else $error("byte input stalled without cause");

	// The result register stays loaded while the verdict is stalled
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !verdict.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled verdict changed");
endmodule

[tb/tb_secure_websocket_url_validator_top.sv]
`timescale 1ns / 100ps

module tb_secure_websocket_url_validator_top;
	import swuv_pkg::*;

	// Index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
		logic              no_data;
	} byte_word_t;

	logic clk = 1'b0;
	logic arst_n;

	swuv_byte_if   chars();
	swuv_result_if verdict();
	swuv_cfg_if    cfg();

	secure_websocket_url_validator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.verdict(verdict),
		.cfg    (cfg)
	);

	always #4 clk = ~clk;

	// Limits as the block should hold them
	logic [CFG_DATA_W-1:0] lim_url  = MAX_URL_RST;
	logic [CFG_DATA_W-1:0] lim_host = MAX_HOST_RST;
	logic [CFG_DATA_W-1:0] lim_path = MAX_PATH_RST;

	// Running parse state of the URL in flight
	logic [BYTE_CNT_W-1:0] p_bytes;
	logic [1:0]            p_kind;
	phase_t                p_phase;
	logic [7:0]            p_flags;
	logic [1:0]            p_colons;
	logic [LEN_W-1:0]      p_host;
	logic [PORT_ACC_W-1:0] p_port;
	logic [2:0]            p_pdigits;
	logic [6:0]            p_label;
	logic [CHAR_W-1:0]     p_prev;
	logic [OCTET_W-1:0]    p_octet;
	logic [2:0]            p_odigits;
	logic [2:0]            p_octets;
	logic [LEN_W-1:0]      p_path;

	string wss_text = "wss://";
	string ws_text  = "ws://";

	byte_word_t        url_words[$];
	result_t           verdicts_due[$];
	logic [CHAR_W-1:0] url_text[$];

	int   words_queued = 0;
	int   words_taken = 0;
	int   urls_posted = 0;
	int   verdicts_seen = 0;
	int   mismatches = 0;
	int   src_odds = 0;
	int   snk_odds = 0;
	int   src_hold = 0;
	int   snk_hold = 0;
	logic byte_fire = 1'b0;

	function automatic logic dec_digit(input logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alnum_char(input logic [CHAR_W-1:0] c);
		return dec_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	task automatic clear_url_state();
		p_bytes = '0; p_kind = '0; p_phase = PH_SCHEME; p_flags = '0;
		p_colons = '0; p_host = '0; p_port = '0; p_pdigits = '0; p_label = '0;
		p_prev = '0; p_octet = '0; p_odigits = '0; p_octets = '0; p_path = '0;
	endtask

	// Track IPv4 and DNS label rules over one host byte
	task automatic scan_host_byte(input logic [CHAR_W-1:0] c);
		if (p_host == 0 && c == "[") p_flags[FL_BRACKET] = 1'b1;
		if (p_host < 255) p_host++;
		if (!dec_digit(c) && c != ".") p_flags[FL_NOTDOTNUM] = 1'b1;
		if (dec_digit(c)) begin
			if (p_odigits >= 3) p_flags[FL_IPV4BAD] = 1'b1;
			else begin
				p_octet = p_octet * 10 + (c - "0");
				p_odigits++;
			end
		end else if (c == ".") begin
			if (p_odigits == 0 || p_octet > OCTET_LIMIT) p_flags[FL_IPV4BAD] = 1'b1;
			if (p_octets < 7) p_octets++;
			p_octet = '0;
			p_odigits = '0;
		end
		if (c == ".") begin
			if (p_label == 0 || p_prev == "-") p_flags[FL_NAMEBAD] = 1'b1;
			p_label = '0;
		end else begin
			if (!alnum_char(c) && c != "-") p_flags[FL_NAMEBAD] = 1'b1;
			if (p_label == 0 && c == "-") p_flags[FL_NAMEBAD] = 1'b1;
			if (p_label >= LABEL_MAX_DEF) p_flags[FL_NAMEBAD] = 1'b1;
			else p_label++;
		end
		p_prev = c;
	endtask

	// Advance the parse state by one URL byte
	task automatic scan_url_byte(input logic [CHAR_W-1:0] c);
		int pos;
		pos = p_bytes;
		if (p_bytes < 511) p_bytes++;
		if (c <= CTRL_TOP || c >= DEL_CHAR) p_flags[FL_BADCHAR] = 1'b1;
		if (p_phase == PH_SCHEME) begin
			if (pos < 6) begin
				if (c != wss_text[pos]) p_kind[0] = 1'b1;
				if (pos < 5 && c != ws_text[pos]) p_kind[1] = 1'b1;
				if (pos == 5 && !p_kind[0]) p_phase = PH_AUTH;
			end
			return;
		end
		if (c == "?" || c == "#") p_flags[FL_QUERY] = 1'b1;
		if (p_phase == PH_AUTH) begin
			if (c == "/") begin
				p_phase = PH_PATH;
				p_path = 1;
				return;
			end
			if (c == "@") p_flags[FL_USERINFO] = 1'b1;
			if (c == ":") begin
				if (p_colons < 3) p_colons++;
			end else if (p_colons == 0) begin
				scan_host_byte(c);
			end else if (p_colons == 1) begin
				if (dec_digit(c) && p_pdigits < 5) begin
					p_port = p_port * 10 + (c - "0");
					p_pdigits++;
				end else begin
					p_pdigits = 3'd7;
				end
			end
			return;
		end
		if (p_path < 255) p_path++;
		if (!alnum_char(c) && c != "-" && c != "." && c != "_" && c != "~" && c != "/")
			p_flags[FL_PATHBAD] = 1'b1;
	endtask

	// Classify the finished URL in priority order
	function automatic status_t url_status(output logic [PORT_W-1:0] used_port,
		output logic dotted);
		used_port = DEFAULT_PORT;
		dotted = 1'b0;
		if (p_bytes == 0) return ST_EMPTY;
		if (p_bytes > lim_url) return ST_TOO_LONG;
		if (p_flags[FL_BADCHAR]) return ST_BAD_CHAR;
		if (!(p_bytes >= 6 && !p_kind[0])) begin
			if (p_bytes >= 5 && !p_kind[1]) return ST_INSECURE;
			return ST_UNSUPPORTED;
		end
		if (p_flags[FL_QUERY]) return ST_QUERY;
		if (p_flags[FL_USERINFO]) return ST_USERINFO;
		if (p_phase != PH_PATH) return ST_NO_PATH;
		if (p_host == 0 || p_flags[FL_BRACKET] || p_colons >= 2 || p_host > lim_host)
			return ST_BAD_HOST;
		if (p_colons == 1) begin
			if (p_pdigits == 0 || p_pdigits > 5) return ST_BAD_PORT;
			if (p_port == 0 || p_port > PORT_LIMIT) return ST_BAD_PORT;
			used_port = p_port[PORT_W-1:0];
		end
		dotted = !p_flags[FL_NOTDOTNUM];
		if (dotted) begin
			if (p_flags[FL_IPV4BAD] || p_odigits == 0 || p_octet > OCTET_LIMIT || p_octets != 3)
				return ST_BAD_HOST;
		end else if (p_flags[FL_NAMEBAD] || p_label == 0 || p_prev == "-") begin
			return ST_BAD_HOST;
		end
		if (p_path > lim_path || p_flags[FL_PATHBAD]) return ST_BAD_PATH;
		return ST_OK;
	endfunction

	function automatic result_t grade_url();
		result_t           r;
		logic [PORT_W-1:0] used_port;
		logic              dotted;
		status_t           st;
		st = url_status(used_port, dotted);
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			r.port = used_port;
			r.is_ipv4 = dotted;
			r.host_length = p_host;
			r.path_length = p_path;
		end
		return r;
	endfunction

	task automatic absorb_word(input byte_word_t w);
		if (!w.no_data) scan_url_byte(w.char_code);
		if (w.last) begin
			verdicts_due.push_back(grade_url());
			clear_url_state();
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) $display("%0t ns verdict %0d: %s", $time, verdicts_seen, what);
	endtask

	// Watch all three channels; predict on accepted words, check verdicts
	always @(posedge clk) begin : watch_channels
		byte_word_t w;
		result_t    want;
		byte_fire <= arst_n && chars.valid && chars.ready;
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MAX_URL:  lim_url = cfg.data;
				REG_MAX_HOST: lim_host = cfg.data;
				REG_MAX_PATH: lim_path = cfg.data;
				default: ;
			endcase
		end
		if (arst_n && chars.valid && chars.ready) begin
			w = '{char_code: chars.char_code, last: chars.last, no_data: chars.no_data};
			words_taken++;
			absorb_word(w);
		end
		if (arst_n && verdict.valid && verdict.ready) begin
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with no URL outstanding");
			end else begin
				want = verdicts_due.pop_front();
				if (verdict.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", verdict.status, want.status));
				if (verdict.port !== want.port)
					report_mismatch($sformatf("port %0d, want %0d", verdict.port, want.port));
				if (verdict.is_ipv4 !== want.is_ipv4)
					report_mismatch($sformatf("is_ipv4 %0b, want %0b", verdict.is_ipv4,
						want.is_ipv4));
				if (verdict.host_length !== want.host_length)
					report_mismatch($sformatf("host_length %0d, want %0d",
						verdict.host_length, want.host_length));
				if (verdict.path_length !== want.path_length)
					report_mismatch($sformatf("path_length %0d, want %0d",
						verdict.path_length, want.path_length));
			end
		end
	end

	// Feed bytes from the queue, with random idle bursts
	always @(negedge clk) begin : feed_words
		byte_word_t w;
		if (arst_n && (!chars.valid || byte_fire)) begin
			if (src_hold > 0) begin
				src_hold--;
				chars.valid <= 1'b0;
			end else if (url_words.size() == 0) begin
				chars.valid <= 1'b0;
			end else if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
				src_hold = $urandom_range(0, 17);
				chars.valid <= 1'b0;
			end else begin
				w = url_words.pop_front();
				chars.valid <= 1'b1;
				chars.char_code <= w.char_code;
				chars.last <= w.last;
				chars.no_data <= w.no_data;
			end
		end
	end

	// Stall the verdict side in random bursts
	always @(negedge clk) begin : take_verdicts
		if (arst_n) begin
			if (snk_hold > 0) begin
				snk_hold--;
				verdict.ready <= 1'b0;
			end else if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
				snk_hold = $urandom_range(0, 17);
				verdict.ready <= 1'b0;
			end else begin
				verdict.ready <= 1'b1;
			end
		end
	end

	task automatic set_limit(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [CFG_DATA_W-1:0] url_max,
		input logic [CFG_DATA_W-1:0] host_max, input logic [CFG_DATA_W-1:0] path_max);
		set_limit(REG_MAX_URL, url_max);
		set_limit(REG_MAX_HOST, host_max);
		set_limit(REG_MAX_PATH, path_max);
	endtask

	task automatic queue_word(input logic [CHAR_W-1:0] c, input logic l, input logic nd);
		url_words.push_back('{char_code: c, last: l, no_data: nd});
		words_queued++;
	endtask

	task automatic add_char(input logic [CHAR_W-1:0] c);
		url_text.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int k = 0; k < s.len(); k++) url_text.push_back(s[k]);
	endtask

	// Send the built text as one URL, with stray blank words now and then
	task automatic post_url(input bit tail_blank);
		int n;
		n = url_text.size();
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 39) == 0) queue_word(8'($urandom), 1'b0, 1'b1);
			queue_word(url_text[k], !tail_blank && k == n - 1, 1'b0);
		end
		if (tail_blank || n == 0) queue_word(8'($urandom), 1'b1, 1'b1);
		urls_posted++;
		url_text = {};
	endtask

	function automatic logic [CHAR_W-1:0] label_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 8'($urandom_range("a", "z"));
		if (r < 72) return 8'($urandom_range("A", "Z"));
		if (r < 88) return 8'($urandom_range("0", "9"));
		return "-";
	endfunction

	function automatic logic [CHAR_W-1:0] path_char();
		string odd;
		int    r;
		odd = "%@!=+;*";
		r = $urandom_range(0, 99);
		if (r < 40) return 8'($urandom_range("a", "z"));
		if (r < 50) return 8'($urandom_range("A", "Z"));
		if (r < 62) return 8'($urandom_range("0", "9"));
		if (r < 70) return "-";
		if (r < 76) return ".";
		if (r < 82) return "_";
		if (r < 86) return "~";
		if (r < 93) return "/";
		if (r < 98) return odd[$urandom_range(0, odd.len() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_dns_host();
		int labels;
		int span;
		labels = $urandom_range(1, 4);
		for (int j = 0; j < labels; j++) begin
			if (j > 0) add_char(".");
			if ($urandom_range(0, 29) == 0) span = $urandom_range(60, 66);
			else if ($urandom_range(0, 24) == 0) span = 0;
			else span = $urandom_range(1, 8);
			repeat (span) add_char(label_char());
		end
		if ($urandom_range(0, 24) == 0) add_char(".");
	endtask

	task automatic add_ipv4_host();
		int octets;
		int r;
		octets = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 5) : 4;
		for (int j = 0; j < octets; j++) begin
			if (j > 0) add_char(".");
			r = $urandom_range(0, 99);
			if (r < 85) add_text($sformatf("%0d", $urandom_range(0, 255)));
			else if (r < 90) add_text($sformatf("%0d", $urandom_range(256, 999)));
			else if (r < 94) add_text($sformatf("%04d", $urandom_range(0, 9999)));
		end
	endtask

	// Build one URL: mostly well formed, with random faults mixed in
	task automatic make_url();
		string odd_host;
		int    r;
		int    k;
		int    span;
		odd_host = "ab9_.-~!*[";
		url_text = {};
		r = $urandom_range(0, 99);
		if (r < 6) begin
			repeat ($urandom_range(0, 12)) add_char(8'($urandom_range(0, 255)));
			post_url($urandom_range(0, 9) == 0);
			return;
		end
		// scheme
		r = $urandom_range(0, 99);
		if (r < 82) add_text(wss_text);
		else if (r < 88) add_text(ws_text);
		else if (r < 94) begin
			k = $urandom_range(0, 5);
			for (int j = 0; j < 6; j++)
				add_char(j == k ? 8'($urandom_range(33, 126)) : 8'(wss_text[j]));
		end else begin
			k = $urandom_range(1, 5);
			for (int j = 0; j < k; j++) add_char(wss_text[j]);
		end
		// user info
		if ($urandom_range(0, 24) == 0) begin
			repeat ($urandom_range(1, 4)) add_char(label_char());
			add_char("@");
		end
		// host
		r = $urandom_range(0, 99);
		if (r < 55) add_dns_host();
		else if (r < 80) add_ipv4_host();
		else if (r < 85) ;
		else if (r < 90) begin
			if ($urandom_range(0, 1)) add_text("[::1]");
			else add_text("[ab]");
		end else begin
			repeat ($urandom_range(1, 6)) add_char(odd_host[$urandom_range(0, odd_host.len() - 1)]);
		end
		// port
		r = $urandom_range(0, 99);
		if (r < 55) ;
		else if (r < 80) add_text($sformatf(":%0d", $urandom_range(1, 65535)));
		else if (r < 84) add_text(":0");
		else if (r < 88) add_text($sformatf(":%0d", $urandom_range(65536, 99999)));
		else if (r < 91) add_text($sformatf(":%0d", $urandom_range(100000, 999999)));
		else if (r < 94) add_text(":");
		else if (r < 97) add_text($sformatf(":%0dx", $urandom_range(1, 99)));
		else add_text($sformatf("::%0d", $urandom_range(1, 999)));
		// path
		if ($urandom_range(0, 19) != 0) begin
			add_char("/");
			span = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 12);
			repeat (span) add_char(path_char());
		end
		// query or fragment
		if ($urandom_range(0, 19) == 0) begin
			add_char($urandom_range(0, 1) ? "?" : "#");
			add_text("q=1");
		end
		post_url($urandom_range(0, 9) == 0);
	endtask

	task automatic long_url(input int n);
		url_text = {};
		add_text("wss://a/");
		repeat (n - 8) add_char("p");
	endtask

	// Wait for every word and verdict of the queued URLs, then let the pipe empty
	task automatic drain();
		while (words_taken != words_queued || verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int byte_goal, input int url_goal);
		int w0;
		int u0;
		w0 = words_queued;
		u0 = urls_posted;
		while (words_queued - w0 < byte_goal || urls_posted - u0 < url_goal) make_url();
		drain();
	endtask

	initial begin
		clear_url_state();
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.last = 1'b0;
		chars.no_data = 1'b0;
		verdict.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed: blank words, empty URL, extreme bytes, short schemes, minimal URLs
		src_odds = 5;
		snk_odds = 5;
		queue_word(8'hFF, 1'b0, 1'b1);
		queue_word(8'h00, 1'b1, 1'b1);
		add_char(8'hFF);
		post_url(0);
		add_char(8'h00);
		post_url(0);
		add_char("w");
		post_url(0);
		add_text(ws_text);
		post_url(0);
		add_text("wss://a/");
		post_url(1);
		add_text(wss_text);
		post_url(0);
		drain();

		// Reset limits
		run_phase(90, 3);

		// Widest host and path limits, URL length boundary at a short limit
		set_limits(8'd40, 8'd255, 8'd255);
		src_odds = 0;
		snk_odds = 3;
		long_url(40);
		post_url(0);
		long_url(41);
		post_url(1);
		run_phase(60, 2);

		// Zero limits
		set_limits(8'd0, 8'd0, 8'd0);
		src_odds = 3;
		snk_odds = 0;
		run_phase(30, 1);

		// Smallest nonzero limits
		set_limits(8'd1, 8'd1, 8'd1);
		run_phase(30, 1);

		// Mid-range limits, plus a write to no register
		set_limits(8'($urandom_range(24, 60)), 8'($urandom_range(3, 16)),
			8'($urandom_range(2, 16)));
		set_limit(REG_UNUSED, 8'($urandom));
		src_odds = $urandom_range(2, 20);
		snk_odds = $urandom_range(2, 20);
		run_phase(90, 3);

		set_limits(8'd200, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
		src_odds = 8;
		snk_odds = 8;
		run_phase(70, 2);

		// Back to reset values, full rate on both sides
		set_limits(MAX_URL_RST, MAX_HOST_RST, MAX_PATH_RST);
		src_odds = 0;
		snk_odds = 0;
		run_phase(90, 3);

		repeat (8) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("run timed out");
		$display("Mismatches found");
		$finish;
	end

endmodule
